### rtl/core/bmh_pkg.sv
// Shared types and constants for the binary max-heap engine.
package bmh_pkg;

    localparam int VAL_W  = 32;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   entry_count;
        logic [VAL_W-1:0]   top_value;
    } t_result;

endpackage

### rtl/core/binary_max_heap_engine.sv
// Binary max-heap engine top level: input handshake and registered result transfer.
// One item at a time: add, remove by value, find or clear on a heap of signed 32-bit
// values held in a 1R1W RAM with one read per cycle. Add climbs the new value level
// by level until it is not greater than its parent or lands in the root. Find scans
// slots from 0 at one slot per cycle, up to the first match or to the entry count when
// absent. Remove adds to the scan a fetch of the last entry and then sifts it up or
// down level by level. The RAM needs no clearing pass after reset. The result waits
// in an output register, so the next item is taken while it is held.
module binary_max_heap_engine
    import bmh_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_action,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_slot,
    output logic [CNT_W-1:0]  o_entry_count,
    output logic [VAL_W-1:0]  o_top_value
);

    logic    seq_ready;
    logic    res_valid;
    logic    res_load;
    t_result res;
    t_result r_res;
    logic    r_out_valid;

    bmh_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_ready     (seq_ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_load),
        .o_res       (res)
    );

    assign res_load = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) r_res <= res;
    end

    assign o_in_stall    = !seq_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_slot        = r_res.slot;
    assign o_entry_count = r_res.entry_count;
    assign o_top_value   = r_res.top_value;

endmodule

### rtl/core/bmh_cmp.sv
// Shared signed compare unit: greater-than and equality of two heap values.
module bmh_cmp
    import bmh_pkg::*;
(
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_gt,
    output logic             o_eq
);

    assign o_gt = $signed(i_a) > $signed(i_b);
    assign o_eq = i_a == i_b;

endmodule

### rtl/core/bmh_seq.sv
// Heap sequencer: 1R1W heap RAM, search and sift control around one compare unit.
module bmh_seq
    import bmh_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = IW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_LAST, S_UCK, S_UWT, S_DRL, S_DWL, S_DWR, S_DMV, S_DONE
    } t_state;

    t_state            r_state, n_state;
    t_action           r_act, n_act;
    t_status           r_status, n_status;
    logic [VAL_W-1:0]  r_x, n_x;
    logic [VAL_W-1:0]  r_bv, n_bv;
    logic [VAL_W-1:0]  r_root;
    logic [IW-1:0]     r_pos, n_pos;
    logic [IW-1:0]     r_slot, n_slot;
    logic [IW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_bi, n_bi;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_rv, n_rv;
    logic              r_first, n_first;

    logic [VAL_W-1:0]  r_mem [CAPACITY];
    logic [VAL_W-1:0]  r_rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_wa, mem_ra;
    logic [VAL_W-1:0]  mem_wd;

    logic [VAL_W-1:0]  cmp_a, cmp_b;
    logic              cmp_gt, cmp_eq;

    logic [IW-1:0]     pos_m1, parent;
    logic [CW-1:0]     cnt_m1;
    logic [LW-1:0]     left, right, cnt_x;

    assign pos_m1 = r_pos - IW'(1);
    assign parent = pos_m1 >> 1;
    assign cnt_m1 = r_cnt - CW'(1);
    assign left   = {1'b0, r_pos, 1'b1};
    assign right  = left + LW'(1);
    assign cnt_x  = LW'(r_cnt);

    assign cmp_a = (r_state == S_UCK || r_state == S_UWT) ? r_x : r_rdata;
    assign cmp_b = (r_state == S_UWT) ? r_rdata :
                   (r_state == S_DWR) ? r_bv : r_x;

    bmh_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt),
        .o_eq (cmp_eq)
    );

    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_status = r_status;
        n_x      = r_x;
        n_bv     = r_bv;
        n_pos    = r_pos;
        n_slot   = r_slot;
        n_k      = r_k;
        n_bi     = r_bi;
        n_i      = r_i;
        n_cnt    = r_cnt;
        n_rv     = r_rv;
        n_first  = r_first;
        mem_we   = 1'b0;
        mem_wa   = r_pos;
        mem_wd   = r_x;
        mem_ra   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act    = t_action'(i_action);
                    n_x      = i_value;
                    n_status = ST_DONE;
                    n_slot   = '0;
                    n_rv     = 1'b0;
                    n_i      = '0;
                    n_first  = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_ADD: begin
                            if (r_cnt == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_pos   = r_cnt[IW-1:0];
                                n_cnt   = r_cnt + CW'(1);
                                n_state = S_UCK;
                            end
                        end
                        ACT_REMOVE, ACT_FIND: n_state = S_SRCH;
                        ACT_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (r_rv && cmp_eq) begin
                    n_rv   = 1'b0;
                    n_pos  = r_k;
                    n_slot = r_k;
                    if (r_act == ACT_REMOVE) begin
                        n_cnt = cnt_m1;
                        if (CW'(r_k) == cnt_m1) begin
                            n_state = S_DONE;
                        end else begin
                            mem_ra  = cnt_m1[IW-1:0];
                            n_state = S_LAST;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_i == r_cnt) begin
                    n_rv     = 1'b0;
                    n_status = ST_MISSING;
                    n_state  = S_DONE;
                end else begin
                    mem_ra = r_i[IW-1:0];
                    n_k    = r_i[IW-1:0];
                    n_i    = r_i + CW'(1);
                    n_rv   = 1'b1;
                end
            end
            S_LAST: begin
                n_x = r_rdata;
                if (r_pos == '0) begin
                    n_state = S_DRL;
                end else begin
                    n_first = 1'b1;
                    n_state = S_UCK;
                end
            end
            S_UCK: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                    if (r_act == ACT_ADD) n_slot = r_pos;
                    n_state = S_DONE;
                end else begin
                    mem_ra  = parent;
                    n_bi    = parent;
                    n_state = S_UWT;
                end
            end
            S_UWT: begin
                if (cmp_gt) begin
                    mem_we  = 1'b1;
                    mem_wd  = r_rdata;
                    n_pos   = r_bi;
                    n_first = 1'b0;
                    n_state = S_UCK;
                end else if (r_first && r_act == ACT_REMOVE) begin
                    n_state = S_DRL;
                end else begin
                    mem_we = 1'b1;
                    if (r_act == ACT_ADD) n_slot = r_pos;
                    n_state = S_DONE;
                end
            end
            S_DRL: begin
                if (left < cnt_x) begin
                    mem_ra  = left[IW-1:0];
                    n_state = S_DWL;
                end else begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DWL: begin
                if (cmp_gt) begin
                    n_bv = r_rdata;
                    n_bi = left[IW-1:0];
                end else begin
                    n_bv = r_x;
                    n_bi = r_pos;
                end
                if (right < cnt_x) begin
                    mem_ra  = right[IW-1:0];
                    n_state = S_DWR;
                end else begin
                    n_state = S_DMV;
                end
            end
            S_DWR: begin
                if (cmp_gt) begin
                    n_bv = r_rdata;
                    n_bi = right[IW-1:0];
                end
                n_state = S_DMV;
            end
            S_DMV: begin
                mem_we = 1'b1;
                if (r_bi == r_pos) begin
                    n_state = S_DONE;
                end else begin
                    mem_wd  = r_bv;
                    n_pos   = r_bi;
                    n_state = S_DRL;
                end
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rv    <= n_rv;
        end
        r_act    <= n_act;
        r_status <= n_status;
        r_x      <= n_x;
        r_bv     <= n_bv;
        r_pos    <= n_pos;
        r_slot   <= n_slot;
        r_k      <= n_k;
        r_bi     <= n_bi;
        r_i      <= n_i;
        r_first  <= n_first;
        if (mem_we && mem_wa == '0) r_root <= mem_wd;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    assign o_ready            = r_state == S_IDLE;
    assign o_res_valid        = r_state == S_DONE;
    assign o_res.status       = r_status;
    assign o_res.slot         = SLOT_W'(r_slot);
    assign o_res.entry_count  = CNT_W'(r_cnt);
    assign o_res.top_value    = (r_cnt != '0) ? r_root : '0;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> r_state != S_IDLE)
        else $error("accepted item did not start");

    a_root_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_wa == '0) |=> r_root == $past(mem_wd))
        else $error("root shadow out of step with slot zero");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid && $stable(r_slot) && $stable(r_cnt))
        else $error("result changed while held");
`endif

endmodule
